[rtl/core/anzc_pkg.sv]
package anzc_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned SHAMT_W = 6;
    localparam int unsigned IN_DATA_W = 144;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [DATA_W-1:0] ERROR_RESULT = 64'hFEED_FACE_DEAD_BEEF;

    typedef enum logic [3:0] {
        KIND_ADD    = 4'd0,
        KIND_SUB    = 4'd1,
        KIND_ORN    = 4'd2,
        KIND_OR     = 4'd3,
        KIND_XOR    = 4'd4,
        KIND_AND    = 4'd5,
        KIND_MOVK   = 4'd6,
        KIND_LSL    = 4'd7,
        KIND_LSR    = 4'd8,
        KIND_ASR    = 4'd9,
        KIND_PASS_A = 4'd10,
        KIND_PASS_B = 4'd11,
        KIND_ERROR  = 4'd12
    } t_kind;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_nzcv;

    typedef struct packed {
        logic [DATA_W-1:0]  operand_a;
        logic [DATA_W-1:0]  operand_b;
        logic [SHAMT_W-1:0] b_shift;
        logic [3:0]         kind;
        logic               set_flags;
        logic [3:0]         condition;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              condition_true;
        t_nzcv             flags_now;
    } t_res;

endpackage

[rtl/core/anzc_alu.sv]
module anzc_alu (
    input  anzc_pkg::t_op   i_op,
    input  anzc_pkg::t_nzcv i_flags,
    output anzc_pkg::t_res  o_res
);
    import anzc_pkg::*;

    logic [DATA_W-1:0] sb;
    logic [DATA_W-1:0] res;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;
    logic [SHAMT_W-1:0] cnt;
    logic              c;
    logic              v;
    t_nzcv             f;
    logic              ct;

    assign sb   = i_op.operand_b << i_op.b_shift;
    assign cnt  = i_op.operand_b[SHAMT_W-1:0];
    assign sum  = {1'b0, i_op.operand_a} + {1'b0, sb};
    // carry out of a + ~b + 1 is the no-borrow flag
    assign diff = {1'b0, i_op.operand_a} + {1'b0, ~sb} + {{DATA_W{1'b0}}, 1'b1};

    always_comb begin
        c = 1'b0;
        v = 1'b0;
        case (t_kind'(i_op.kind))
            KIND_ADD: begin
                res = sum[DATA_W-1:0];
                c   = sum[DATA_W];
                v   = ~(i_op.operand_a[DATA_W-1] ^ sb[DATA_W-1])
                      & (i_op.operand_a[DATA_W-1] ^ res[DATA_W-1]);
            end
            KIND_SUB: begin
                res = diff[DATA_W-1:0];
                c   = diff[DATA_W];
                v   = (i_op.operand_a[DATA_W-1] ^ sb[DATA_W-1])
                      & (i_op.operand_a[DATA_W-1] ^ res[DATA_W-1]);
            end
            KIND_ORN:    res = i_op.operand_a | ~i_op.operand_b;
            KIND_OR:     res = i_op.operand_a | i_op.operand_b;
            KIND_XOR:    res = i_op.operand_a ^ i_op.operand_b;
            KIND_AND:    res = i_op.operand_a & i_op.operand_b;
            KIND_MOVK:   res = i_op.operand_a | sb;
            KIND_LSL:    res = i_op.operand_a << cnt;
            KIND_LSR:    res = i_op.operand_a >> cnt;
            KIND_ASR:    res = DATA_W'($signed(i_op.operand_a) >>> cnt);
            KIND_PASS_A: res = i_op.operand_a;
            KIND_PASS_B: res = i_op.operand_b;
            default:     res = ERROR_RESULT;
        endcase
    end

    always_comb begin
        if (i_op.set_flags) begin
            f.n = res[DATA_W-1];
            f.z = (res == '0);
            f.c = c;
            f.v = v;
        end else begin
            f = i_flags;
        end
    end

    always_comb begin
        case (t_cond'(i_op.condition))
            COND_EQ: ct = f.z;
            COND_NE: ct = ~f.z;
            COND_CS: ct = f.c;
            COND_CC: ct = ~f.c;
            COND_MI: ct = f.n;
            COND_PL: ct = ~f.n;
            COND_VS: ct = f.v;
            COND_VC: ct = ~f.v;
            COND_HI: ct = f.c & ~f.z;
            COND_LS: ct = ~(f.c & ~f.z);
            COND_GE: ct = (f.n == f.v);
            COND_LT: ct = (f.n != f.v);
            COND_GT: ct = (f.n == f.v) & ~f.z;
            COND_LE: ct = ~((f.n == f.v) & ~f.z);
            default: ct = 1'b1;
        endcase
    end

    assign o_res.result         = res;
    assign o_res.condition_true = ct;
    assign o_res.flags_now      = f;

endmodule

[rtl/core/alu_with_nzcv_and_condition.sv]
// 64-bit ALU with stored NZCV flags and an ARM condition check. Each item
// is registered on input, evaluated in one pass (operation, flag update,
// condition test) and registered on output, and one item is taken per
// cycle while the output is not held back; the only feedback is the 4-bit
// flag register, written as the item moves into the output register. Flags
// reset to zero. Kinds 12 to 15 act as the error code.
module alu_with_nzcv_and_condition (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // operand_a, operand_b, b_shift, set_flags, condition, zero pad
    input  logic [anzc_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // kind
    input  logic [3:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // result, condition_true, flags_now (N,Z,C,V from bit 3 down), zero pad
    output logic [anzc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import anzc_pkg::*;

    localparam int unsigned IN_USED_W = 2 * DATA_W + SHAMT_W + 1 + 4;
    localparam int unsigned OUT_USED_W = DATA_W + 1 + 4;

    logic  r_v1;
    t_op   r_op;
    logic  r_ov;
    t_res  r_out;
    t_nzcv r_flags;
    t_res  n_out;
    logic  w_adv;
    logic  w_take;

    assign w_adv  = ~r_ov | i_m_axis_tready;
    assign w_take = w_adv & r_v1;
    assign o_s_axis_tready = w_adv | ~r_v1;

    anzc_alu u_alu (
        .i_op    (r_op),
        .i_flags (r_flags),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
            r_flags <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_ov <= r_v1;
            end
            if (w_take) begin
                r_flags <= n_out.flags_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_op.operand_a <= i_s_axis_tdata[DATA_W-1:0];
            r_op.operand_b <= i_s_axis_tdata[2*DATA_W-1:DATA_W];
            r_op.b_shift   <= i_s_axis_tdata[2*DATA_W+SHAMT_W-1:2*DATA_W];
            r_op.set_flags <= i_s_axis_tdata[2*DATA_W+SHAMT_W];
            r_op.condition <= i_s_axis_tdata[IN_USED_W-1:2*DATA_W+SHAMT_W+1];
            r_op.kind      <= i_s_axis_tuser;
        end
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                              r_out.flags_now, r_out.condition_true, r_out.result};

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_flags))
        else $error("flags changed without an item moving");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.flags_now == r_flags))
        else $error("delivered flags differ from stored flags");

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_ov)
        else $error("item lost between stages");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ov && !r_v1)
        else $error("pipeline not empty after reset");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import anzc_pkg::*;

    localparam logic [3:0] KIND_SPARE_13 = 4'd13;
    localparam logic [3:0] KIND_SPARE_14 = 4'd14;
    localparam logic [3:0] KIND_SPARE_15 = 4'd15;
    localparam int unsigned IDLE_PCT = 21;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT = 20000;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  b_shift;
        logic [3:0]  kind;
        logic        set_flags;
        logic [3:0]  cond;
    } t_alu_op;

    typedef struct {
        logic [63:0] result;
        logic        cond_true;
        t_nzcv       flags;
    } t_alu_out;

    typedef struct {
        t_alu_op  op;
        bit       typed;
        t_alu_out want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [3:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    alu_with_nzcv_and_condition u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_stim_row stim_q[$];
    t_alu_out  expected_outs[$];
    t_nzcv     nzcv_model;
    bit        idle_on;
    bit        hold_req;
    int        fail_cnt;
    int        n_checked;
    int        n_flag_sets;
    int        n_cond_hits;
    bit        kind_seen[16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("alu_with_nzcv_and_condition: mismatch");
        $finish;
    end

    function automatic t_alu_out alu_eval(t_alu_op op);
        logic [63:0] sb;
        logic [64:0] wide;
        logic        c;
        logic        v;
        logic        hit;
        t_alu_out    o;
        sb = op.b << op.b_shift;
        c = 1'b0;
        v = 1'b0;
        case (op.kind)
            KIND_ADD: begin
                wide = {1'b0, op.a} + {1'b0, sb};
                o.result = wide[63:0];
                c = wide[64];
                v = (op.a[63] == sb[63]) && (o.result[63] != op.a[63]);
            end
            KIND_SUB: begin
                o.result = op.a - sb;
                c = op.a >= sb;
                v = (op.a[63] != sb[63]) && (o.result[63] != op.a[63]);
            end
            KIND_ORN:    o.result = op.a | ~op.b;
            KIND_OR:     o.result = op.a | op.b;
            KIND_XOR:    o.result = op.a ^ op.b;
            KIND_AND:    o.result = op.a & op.b;
            KIND_MOVK:   o.result = op.a | sb;
            KIND_LSL:    o.result = op.a << op.b[5:0];
            KIND_LSR:    o.result = op.a >> op.b[5:0];
            KIND_ASR:    o.result = $signed(op.a) >>> op.b[5:0];
            KIND_PASS_A: o.result = op.a;
            KIND_PASS_B: o.result = op.b;
            default:     o.result = ERROR_RESULT;
        endcase
        if (op.set_flags) begin
            nzcv_model.n = o.result[63];
            nzcv_model.z = (o.result == 64'd0);
            nzcv_model.c = c;
            nzcv_model.v = v;
        end
        case (op.cond)
            COND_EQ, COND_NE: hit = nzcv_model.z;
            COND_CS, COND_CC: hit = nzcv_model.c;
            COND_MI, COND_PL: hit = nzcv_model.n;
            COND_VS, COND_VC: hit = nzcv_model.v;
            COND_HI, COND_LS: hit = nzcv_model.c && !nzcv_model.z;
            COND_GE, COND_LT: hit = (nzcv_model.n == nzcv_model.v);
            COND_GT, COND_LE: hit = (nzcv_model.n == nzcv_model.v) && !nzcv_model.z;
            default:          hit = 1'b1;
        endcase
        if (op.cond != COND_AL && op.cond != COND_NV && op.cond[0]) begin
            hit = !hit;
        end
        o.cond_true = hit;
        o.flags = nzcv_model;
        return o;
    endfunction

    function automatic t_alu_op mk_op(logic [63:0] a, logic [63:0] b, logic [5:0] sh,
                                      logic [3:0] kind, logic set, logic [3:0] cond);
        t_alu_op op;
        op.a = a;
        op.b = b;
        op.b_shift = sh;
        op.kind = kind;
        op.set_flags = set;
        op.cond = cond;
        return op;
    endfunction

    function automatic void put(t_alu_op op, bit typed = 1'b0, logic [63:0] r = '0,
                                logic ct = 1'b0, logic [3:0] f = '0);
        t_stim_row row;
        row.op = op;
        row.typed = typed;
        row.want.result = r;
        row.want.cond_true = ct;
        row.want.flags = f;
        stim_q.push_back(row);
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void build_random(int count);
        t_alu_op op;
        for (int i = 0; i < count; i++) begin
            op.a = pick_word();
            op.b = pick_word();
            op.b_shift = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(63));
            op.kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                      4'($urandom_range(12));
            if ($urandom_range(9) == 0) begin
                op.b = op.a;
                op.b_shift = 6'd0;
            end
            op.set_flags = ($urandom_range(99) < 60);
            op.cond = 4'($urandom_range(15));
            put(op);
        end
    endfunction

    function automatic void build_directed();
        // typed rows: reset flags, carry/overflow/borrow extremes, error code
        put(mk_op(64'd0, 64'd1, 6'd0, KIND_PASS_B, 1'b0, COND_EQ), 1'b1, 64'd1, 1'b0,
            4'b0000);
        put(mk_op(64'd0, 64'd0, 6'd0, KIND_PASS_A, 1'b1, COND_EQ), 1'b1, 64'd0, 1'b1,
            4'b0100);
        put(mk_op(64'd3, 64'd4, 6'd0, KIND_ERROR, 1'b1, COND_MI), 1'b1, ERROR_RESULT, 1'b1,
            4'b1000);
        put(mk_op('1, 64'd1, 6'd0, KIND_ADD, 1'b1, COND_CS), 1'b1, 64'd0, 1'b1, 4'b0110);
        put(mk_op(64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 6'd0, KIND_ADD, 1'b1, COND_VS), 1'b1,
            64'h8000_0000_0000_0000, 1'b1, 4'b1001);
        put(mk_op(64'd0, 64'd1, 6'd0, KIND_SUB, 1'b1, COND_CC), 1'b1, '1, 1'b1, 4'b1000);
        put(mk_op(64'd5, 64'd5, 6'd0, KIND_SUB, 1'b1, COND_HI), 1'b1, 64'd0, 1'b0,
            4'b0110);
        put(mk_op(64'h8000_0000_0000_0000, 64'd1, 6'd0, KIND_SUB, 1'b1, COND_GE), 1'b1,
            64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 4'b0011);
        put(mk_op(64'd0, 64'd1, 6'd63, KIND_ADD, 1'b1, COND_LT));
        put(mk_op(64'd0, '1, 6'd0, KIND_ORN, 1'b1, COND_EQ));
        put(mk_op(64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 6'd0, KIND_OR, 1'b0,
                  COND_NE));
        put(mk_op('1, '1, 6'd0, KIND_XOR, 1'b1, COND_PL));
        put(mk_op(64'h8000_0000_0000_0000, '1, 6'd0, KIND_AND, 1'b1, COND_MI));
        put(mk_op(64'h0000_FFFF, 64'hABCD, 6'd16, KIND_MOVK, 1'b1, COND_VC));
        put(mk_op(64'd1, 64'd63, 6'd0, KIND_LSL, 1'b1, COND_LS));
        put(mk_op(64'h8000_0000_0000_0000, 64'd64, 6'd0, KIND_LSR, 1'b1, COND_GT));
        put(mk_op(64'h8000_0000_0000_0000, 64'd63, 6'd0, KIND_ASR, 1'b1, COND_LE));
        put(mk_op(64'd0, '1, 6'd0, KIND_PASS_B, 1'b0, COND_NV));
        put(mk_op(64'd1, 64'd2, 6'd5, KIND_SPARE_13, 1'b1, COND_AL));
        put(mk_op(64'd1, 64'd2, 6'd0, KIND_SPARE_14, 1'b0, COND_GE));
        put(mk_op('1, '1, 6'd63, KIND_SPARE_15, 1'b1, COND_HI));
        put(mk_op(64'd0, 64'd0, 6'd63, KIND_SUB, 1'b1, COND_CS));
        put(mk_op(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 6'd0, KIND_ADD, 1'b1,
                  COND_VS));
        put(mk_op(64'd1, 64'd1, 6'd1, KIND_SUB, 1'b1, COND_GT));
        put(mk_op(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC1, 6'd0, KIND_ASR, 1'b0,
                  COND_NE));
    endfunction

    task automatic send_items();
        t_stim_row row;
        t_alu_out  pred;
        while (stim_q.size() > 0) begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(99) < IDLE_PCT) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                row = stim_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {5'd0, row.op.cond, row.op.set_flags, row.op.b_shift,
                                   row.op.b, row.op.a};
                i_s_axis_tuser <= row.op.kind;
                @(posedge i_clk);
                while (!o_s_axis_tready) @(posedge i_clk);
                pred = alu_eval(row.op);
                if (row.typed) pred = row.want;
                expected_outs.push_back(pred);
                kind_seen[row.op.kind] = 1'b1;
                if (row.op.set_flags) n_flag_sets++;
            end
        end
    endtask

    task automatic check_item(logic [OUT_DATA_W-1:0] d);
        t_alu_out want;
        if (expected_outs.size() == 0) begin
            $error("unexpected item: result %h", d[63:0]);
            fail_cnt++;
        end else begin
            want = expected_outs.pop_front();
            n_checked++;
            if (d[64]) n_cond_hits++;
            if (d[63:0] !== want.result) begin
                $error("result: expected %h, got %h", want.result, d[63:0]);
                fail_cnt++;
            end
            if (d[64] !== want.cond_true) begin
                $error("condition_true: expected %b, got %b", want.cond_true, d[64]);
                fail_cnt++;
            end
            if (d[68:65] !== want.flags) begin
                $error("flags_now: expected %b, got %b", want.flags, d[68:65]);
                fail_cnt++;
            end
        end
    endtask

    // receiver: random backpressure plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) check_item(o_m_axis_tdata);
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int waited;
        int kinds;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        fail_cnt = 0;
        n_checked = 0;
        n_flag_sets = 0;
        n_cond_hits = 0;
        nzcv_model = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        build_directed();
        send_items();

        hold_req = 1'b1;
        build_random(700);
        send_items();

        idle_on = 1'b0;
        build_random(400);
        send_items();

        idle_on = 1'b1;
        build_random(900);
        send_items();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        waited = 0;
        while (expected_outs.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_outs.size() > 0) begin
            $error("%0d items never came out", expected_outs.size());
            fail_cnt += expected_outs.size();
        end

        kinds = 0;
        foreach (kind_seen[k]) if (kind_seen[k]) kinds++;
        $display("checked %0d items over %0d of 16 op codes, %0d flag updates",
                 n_checked, kinds, n_flag_sets);
        $display("%0d condition hits, %0d errors", n_cond_hits, fail_cnt);
        if (fail_cnt == 0) begin
            $display("alu_with_nzcv_and_condition: match");
        end else begin
            $display("alu_with_nzcv_and_condition: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/anzc_pkg.sv
rtl/core/anzc_alu.sv
rtl/core/alu_with_nzcv_and_condition.sv
tb/testbench.sv
